@@ sv/dbsm_pkg.sv @@
// Shared types, codes and constants of the debug breakpoint slot manager.
// Used by dbsm_ctrl, dbsm_datapath and debug_breakpoint_slot_manager; no dependencies.
`default_nettype none

package dbsm_pkg;

	// Number of breakpoint slots and the width of a slot index.
	localparam int NUM_SLOTS = 4;
	localparam int SLOT_W    = 2;

	// Command codes.
	localparam logic [2:0] CMD_ALLOC     = 3'd0;
	localparam logic [2:0] CMD_ENABLE    = 3'd1;
	localparam logic [2:0] CMD_DISABLE   = 3'd2;
	localparam logic [2:0] CMD_CLEAR     = 3'd3;
	localparam logic [2:0] CMD_CLEAR_ALL = 3'd4;
	localparam logic [2:0] CMD_TRAP      = 3'd5;

	// Slot state codes.
	localparam logic [1:0] ST_EMPTY    = 2'd0;
	localparam logic [1:0] ST_DISABLED = 2'd1;
	localparam logic [1:0] ST_ENABLED  = 2'd2;

	// Access kind codes.
	localparam logic [1:0] KIND_EXEC  = 2'd0;
	localparam logic [1:0] KIND_WRITE = 2'd1;
	localparam logic [1:0] KIND_RDWR  = 2'd2;

	// Target state codes.
	localparam logic [1:0] TGT_RUNNING = 2'd1;
	localparam logic [1:0] TGT_STOPPED = 2'd2;

	// Result status codes.
	localparam logic [1:0] STAT_OK  = 2'd0;
	localparam logic [1:0] STAT_ERR = 2'd1;
	localparam logic [1:0] STAT_HIT = 2'd2;

	// Debug register numbers.
	localparam logic [2:0] REG_DR6 = 3'd6;
	localparam logic [2:0] REG_DR7 = 3'd7;

	// DR7 field positions.
	localparam int DR7_RW_BASE  = 16;
	localparam int DR7_LEN_BASE = 18;
	localparam int DR7_STRIDE   = 4;

	// Register write sequence that a command calls for.
	typedef enum logic [1:0] {
		SEQ_NONE,
		SEQ_PROGRAM,
		SEQ_WIPE,
		SEQ_TRAP
	} seq_t;

	// Kind of result the datapath loads into its output register.
	typedef enum logic [2:0] {
		EMIT_NONE,
		EMIT_DR7Z,
		EMIT_ADDR,
		EMIT_DR7,
		EMIT_DR6Z,
		EMIT_STATUS
	} emit_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic              load;
		logic              decide;
		emit_t             emit;
		logic [SLOT_W-1:0] idx;
	} dp_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		seq_t seq;
	} dp_stat_t;

endpackage

`default_nettype wire

@@ sv/debug_breakpoint_slot_manager.sv @@
// Top level of the debug breakpoint slot manager.
// Depends on dbsm_pkg, dbsm_ctrl and dbsm_datapath.
//
// An item (one command) is accepted when start is high and busy is low. The
// block answers with zero to six debug register writes followed by one status
// result flagged by last; each result is on the ports for exactly one cycle,
// marked by result_valid, and the receiver must take it then. A command keeps
// busy high from its decide step through its status step. The controller
// walks one step per cycle: decide, DR7=0, DR0..DR3, final DR7 or DR6, status;
// a full reprogramming or clear-all takes every step, a trap hit only decide,
// DR6 and status, and a command without register writes decide and status.
// The next item is taken in idle. Results are registered and appear in the
// cycle after the step that makes them; busy falls as the status leaves the
// controller, so a new item may be accepted while that status is shown.
`default_nettype none

module debug_breakpoint_slot_manager (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [2:0]  cmd,
	input  wire logic [2:0]  slot_id,
	input  wire logic [63:0] address,
	input  wire logic [1:0]  access_kind,
	input  wire logic [3:0]  length_bytes,
	input  wire logic [1:0]  target_state,
	input  wire logic [63:0] dr6_value,
	output logic             result_valid,
	output logic             is_reg_write,
	output logic [2:0]       reg_number,
	output logic [63:0]      reg_value,
	output logic [1:0]       status,
	output logic [1:0]       slot_out,
	output logic             last
);

	dbsm_pkg::dp_cmd_t  dp_cmd;
	dbsm_pkg::dp_stat_t dp_stat;

	// Sequencing of decide and result steps.
	dbsm_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.busy    (busy),
		.dp_stat (dp_stat),
		.dp_cmd  (dp_cmd)
	);

	// Slot table, decision logic and result register.
	dbsm_datapath u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.dp_cmd       (dp_cmd),
		.dp_stat      (dp_stat),
		.cmd          (cmd),
		.slot_id      (slot_id),
		.address      (address),
		.access_kind  (access_kind),
		.length_bytes (length_bytes),
		.target_state (target_state),
		.dr6_value    (dr6_value),
		.result_valid (result_valid),
		.is_reg_write (is_reg_write),
		.reg_number   (reg_number),
		.reg_value    (reg_value),
		.status       (status),
		.slot_out     (slot_out),
		.last         (last)
	);

endmodule

`default_nettype wire

@@ sv/dbsm_ctrl.sv @@
// Controller state machine of the debug breakpoint slot manager.
// Depends on dbsm_pkg; drives dbsm_datapath through dp_cmd_t.
`default_nettype none

module dbsm_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	output logic                   busy,
	input  wire dbsm_pkg::dp_stat_t dp_stat,
	output dbsm_pkg::dp_cmd_t      dp_cmd
);

	typedef enum logic [5:0] {
		S_IDLE   = 6'b000001,
		S_DECIDE = 6'b000010,
		S_DR7Z   = 6'b000100,
		S_ADDR   = 6'b001000,
		S_FINAL  = 6'b010000,
		S_STATUS = 6'b100000
	} state_t;

	localparam logic [dbsm_pkg::SLOT_W-1:0] LAST_IDX =
		dbsm_pkg::SLOT_W'(dbsm_pkg::NUM_SLOTS - 1);

	state_t                        state_q, state_d;
	dbsm_pkg::seq_t                seq_q;
	logic [dbsm_pkg::SLOT_W-1:0]   cnt_q;

	assign busy = (state_q != S_IDLE);

	// Next state and datapath commands.
	always_comb begin
		state_d       = state_q;
		dp_cmd.load   = 1'b0;
		dp_cmd.decide = 1'b0;
		dp_cmd.emit   = dbsm_pkg::EMIT_NONE;
		dp_cmd.idx    = cnt_q;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					dp_cmd.load = 1'b1;
					state_d     = S_DECIDE;
				end
			end
			S_DECIDE: begin
				dp_cmd.decide = 1'b1;
				case (dp_stat.seq)
					dbsm_pkg::SEQ_PROGRAM, dbsm_pkg::SEQ_WIPE: state_d = S_DR7Z;
					dbsm_pkg::SEQ_TRAP:                        state_d = S_FINAL;
					default:                                   state_d = S_STATUS;
				endcase
			end
			S_DR7Z: begin
				dp_cmd.emit = dbsm_pkg::EMIT_DR7Z;
				state_d     = S_ADDR;
			end
			S_ADDR: begin
				dp_cmd.emit = dbsm_pkg::EMIT_ADDR;
				if (cnt_q == LAST_IDX) begin
					state_d = S_FINAL;
				end
			end
			S_FINAL: begin
				dp_cmd.emit = (seq_q == dbsm_pkg::SEQ_PROGRAM) ? dbsm_pkg::EMIT_DR7
				                                               : dbsm_pkg::EMIT_DR6Z;
				state_d     = S_STATUS;
			end
			S_STATUS: begin
				dp_cmd.emit = dbsm_pkg::EMIT_STATUS;
				state_d     = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// State, sequence kind and slot counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			seq_q   <= dbsm_pkg::SEQ_NONE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == S_DECIDE) begin
				seq_q <= dp_stat.seq;
			end
			if (state_q == S_DR7Z) begin
				cnt_q <= '0;
			end else if (state_q == S_ADDR) begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	// An accepted item always moves the controller out of idle.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (state_q == S_DECIDE))
		else $error("accepted item did not enter the decide step");

	// The status result is always the last step of an item.
	a_status_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_STATUS) |=> (state_q == S_IDLE))
		else $error("controller did not return to idle after the status result");

endmodule

`default_nettype wire

@@ sv/dbsm_datapath.sv @@
// Datapath of the debug breakpoint slot manager: input latch, slot table,
// command decision, DR7 build and the result register. Depends on dbsm_pkg.
`default_nettype none

module dbsm_datapath (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire dbsm_pkg::dp_cmd_t dp_cmd,
	output dbsm_pkg::dp_stat_t     dp_stat,
	input  wire logic [2:0]        cmd,
	input  wire logic [2:0]        slot_id,
	input  wire logic [63:0]       address,
	input  wire logic [1:0]        access_kind,
	input  wire logic [3:0]        length_bytes,
	input  wire logic [1:0]        target_state,
	input  wire logic [63:0]       dr6_value,
	output logic                   result_valid,
	output logic                   is_reg_write,
	output logic [2:0]             reg_number,
	output logic [63:0]            reg_value,
	output logic [1:0]             status,
	output logic [1:0]             slot_out,
	output logic                   last
);

	localparam int N = dbsm_pkg::NUM_SLOTS;
	localparam int W = dbsm_pkg::SLOT_W;

	// Checks that a kind, length and address form a legal breakpoint.
	function automatic logic legal_bp(input logic [1:0] kind, input logic [3:0] len,
	                                  input logic [3:0] addr_lo);
		logic len_ok;
		len_ok = (len == 4'd1) || (len == 4'd2) || (len == 4'd4) || (len == 4'd8);
		case (kind)
			dbsm_pkg::KIND_EXEC:                      legal_bp = (len == 4'd1);
			dbsm_pkg::KIND_WRITE, dbsm_pkg::KIND_RDWR:
				legal_bp = len_ok && ((addr_lo & (len - 4'd1)) == 4'd0);
			default:                                  legal_bp = 1'b0;
		endcase
	endfunction

	// Latched input item.
	logic [2:0]  cmd_q;
	logic [2:0]  id_q;
	logic [63:0] addr_q;
	logic [1:0]  kind_q;
	logic [3:0]  len_q;
	logic [1:0]  ts_q;
	logic [63:0] dr6_q;

	// Slot table.
	logic [1:0]  slot_state_q   [N];
	logic [1:0]  slot_kind_q    [N];
	logic [63:0] slot_address_q [N];
	logic [3:0]  slot_length_q  [N];

	// Final status remembered from the decide step.
	logic [1:0]  fin_status_q;
	logic [W-1:0] fin_slot_q;
	logic [63:0] fin_value_q;

	// Result register.
	logic        out_valid_q;
	logic        out_wr_q;
	logic [2:0]  out_reg_q;
	logic [63:0] out_value_q;
	logic [1:0]  out_status_q;
	logic [W-1:0] out_slot_q;
	logic        out_last_q;

	// Next contents of the result register.
	logic        out_wr_d;
	logic [2:0]  out_reg_d;
	logic [63:0] out_value_d;
	logic [1:0]  out_status_d;
	logic [W-1:0] out_slot_d;
	logic        out_last_d;

	// Decision outputs.
	logic [1:0]   d_status;
	logic [W-1:0] d_slot;
	logic [63:0]  d_value;
	logic         d_alloc;
	logic         d_set_state;
	logic [1:0]   d_new_state;
	logic         d_wipe_one;
	logic         d_wipe_all;
	dbsm_pkg::seq_t d_seq;

	logic         live;
	logic         stopped;
	logic         id_ok;
	logic [W-1:0] idx;
	logic         free_found;
	logic [W-1:0] free_idx;
	logic         hit_found;
	logic [W-1:0] hit_idx;
	logic [63:0]  dr7;

	assign live    = (ts_q == dbsm_pkg::TGT_RUNNING) || (ts_q == dbsm_pkg::TGT_STOPPED);
	assign stopped = (ts_q == dbsm_pkg::TGT_STOPPED);
	assign id_ok   = ({1'b0, id_q} < 4'(N));
	assign idx     = id_q[W-1:0];

	// First empty slot and lowest enabled slot hit in DR6.
	always_comb begin
		free_found = 1'b0;
		free_idx   = '0;
		hit_found  = 1'b0;
		hit_idx    = '0;
		for (int i = N - 1; i >= 0; i--) begin
			if (slot_state_q[i] == dbsm_pkg::ST_EMPTY) begin
				free_found = 1'b1;
				free_idx   = W'(i);
			end
			if (dr6_q[i] && (slot_state_q[i] == dbsm_pkg::ST_ENABLED)) begin
				hit_found = 1'b1;
				hit_idx   = W'(i);
			end
		end
	end

	// Command decision on the latched item and the current table.
	always_comb begin
		d_status    = dbsm_pkg::STAT_ERR;
		d_slot      = '0;
		d_value     = '0;
		d_alloc     = 1'b0;
		d_set_state = 1'b0;
		d_new_state = dbsm_pkg::ST_DISABLED;
		d_wipe_one  = 1'b0;
		d_wipe_all  = 1'b0;
		d_seq       = dbsm_pkg::SEQ_NONE;
		case (cmd_q)
			dbsm_pkg::CMD_ALLOC: begin
				if (legal_bp(kind_q, len_q, addr_q[3:0]) && free_found) begin
					d_alloc  = 1'b1;
					d_status = dbsm_pkg::STAT_OK;
					d_slot   = free_idx;
				end
			end
			dbsm_pkg::CMD_ENABLE, dbsm_pkg::CMD_DISABLE: begin
				if (id_ok && (slot_state_q[idx] != dbsm_pkg::ST_EMPTY)) begin
					if (cmd_q == dbsm_pkg::CMD_DISABLE ||
					    legal_bp(slot_kind_q[idx], slot_length_q[idx],
					             slot_address_q[idx][3:0])) begin
						d_set_state = 1'b1;
						d_new_state = (cmd_q == dbsm_pkg::CMD_ENABLE) ? dbsm_pkg::ST_ENABLED
						                                             : dbsm_pkg::ST_DISABLED;
						d_status    = dbsm_pkg::STAT_OK;
						d_seq       = stopped ? dbsm_pkg::SEQ_PROGRAM : dbsm_pkg::SEQ_NONE;
					end
				end
			end
			dbsm_pkg::CMD_CLEAR: begin
				if (id_ok) begin
					d_status = dbsm_pkg::STAT_OK;
					if (slot_state_q[idx] != dbsm_pkg::ST_EMPTY) begin
						d_wipe_one = 1'b1;
						d_seq      = stopped ? dbsm_pkg::SEQ_PROGRAM : dbsm_pkg::SEQ_NONE;
					end
				end
			end
			dbsm_pkg::CMD_CLEAR_ALL: begin
				d_wipe_all = 1'b1;
				d_status   = dbsm_pkg::STAT_OK;
				d_seq      = stopped ? dbsm_pkg::SEQ_WIPE : dbsm_pkg::SEQ_NONE;
			end
			dbsm_pkg::CMD_TRAP: begin
				if (live) begin
					d_value = dr6_q;
					if (hit_found) begin
						d_status = dbsm_pkg::STAT_HIT;
						d_slot   = hit_idx;
						d_seq    = dbsm_pkg::SEQ_TRAP;
					end else begin
						d_status = dbsm_pkg::STAT_OK;
					end
				end
			end
			default: begin
				d_status = dbsm_pkg::STAT_ERR;
			end
		endcase
	end

	assign dp_stat.seq = d_seq;

	// DR7 image built from the enabled slots.
	always_comb begin
		logic [1:0] rw;
		logic [1:0] lf;
		logic       ok;
		dr7 = '0;
		for (int i = 0; i < N; i++) begin
			ok = (slot_state_q[i] == dbsm_pkg::ST_ENABLED);
			case (slot_kind_q[i])
				dbsm_pkg::KIND_EXEC:  rw = 2'd0;
				dbsm_pkg::KIND_WRITE: rw = 2'd1;
				dbsm_pkg::KIND_RDWR:  rw = 2'd3;
				default: begin
					rw = 2'd0;
					ok = 1'b0;
				end
			endcase
			case (slot_length_q[i])
				4'd1:    lf = 2'd0;
				4'd2:    lf = 2'd1;
				4'd4:    lf = 2'd3;
				4'd8:    lf = 2'd2;
				default: begin
					lf = 2'd0;
					ok = 1'b0;
				end
			endcase
			if (ok) begin
				dr7[2*i] = 1'b1;
				dr7[dbsm_pkg::DR7_RW_BASE + dbsm_pkg::DR7_STRIDE*i +: 2]  = rw;
				dr7[dbsm_pkg::DR7_LEN_BASE + dbsm_pkg::DR7_STRIDE*i +: 2] = lf;
			end
		end
	end

	// Input latch and final status, no reset needed.
	always_ff @(posedge clk) begin
		if (dp_cmd.load) begin
			cmd_q  <= cmd;
			id_q   <= slot_id;
			addr_q <= address;
			kind_q <= access_kind;
			len_q  <= length_bytes;
			ts_q   <= target_state;
			dr6_q  <= dr6_value;
		end
		if (dp_cmd.decide) begin
			fin_status_q <= d_status;
			fin_slot_q   <= d_slot;
			fin_value_q  <= d_value;
		end
	end

	// Slot table update at the decide step.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < N; i++) begin
				slot_state_q[i]   <= dbsm_pkg::ST_EMPTY;
				slot_kind_q[i]    <= '0;
				slot_address_q[i] <= '0;
				slot_length_q[i]  <= '0;
			end
		end else if (dp_cmd.decide) begin
			for (int i = 0; i < N; i++) begin
				if (d_wipe_all || (d_wipe_one && idx == W'(i))) begin
					slot_state_q[i]   <= dbsm_pkg::ST_EMPTY;
					slot_kind_q[i]    <= '0;
					slot_address_q[i] <= '0;
					slot_length_q[i]  <= '0;
				end else if (d_alloc && free_idx == W'(i)) begin
					slot_state_q[i]   <= dbsm_pkg::ST_DISABLED;
					slot_kind_q[i]    <= kind_q;
					slot_address_q[i] <= addr_q;
					slot_length_q[i]  <= len_q;
				end else if (d_set_state && idx == W'(i)) begin
					slot_state_q[i] <= d_new_state;
				end
			end
		end
	end

	// Result register: one result per emit command, shown for one cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= (dp_cmd.emit != dbsm_pkg::EMIT_NONE);
		end
	end

	// Contents of the next result, selected by the emit command.
	always_comb begin
		out_wr_d     = 1'b1;
		out_reg_d    = '0;
		out_value_d  = '0;
		out_status_d = dbsm_pkg::STAT_OK;
		out_slot_d   = '0;
		out_last_d   = 1'b0;
		case (dp_cmd.emit)
			dbsm_pkg::EMIT_DR7Z: begin
				out_reg_d = dbsm_pkg::REG_DR7;
			end
			dbsm_pkg::EMIT_ADDR: begin
				out_reg_d   = 3'(dp_cmd.idx);
				out_value_d = (slot_state_q[dp_cmd.idx] == dbsm_pkg::ST_ENABLED)
				              ? slot_address_q[dp_cmd.idx] : 64'd0;
			end
			dbsm_pkg::EMIT_DR7: begin
				out_reg_d   = dbsm_pkg::REG_DR7;
				out_value_d = dr7;
			end
			dbsm_pkg::EMIT_DR6Z: begin
				out_reg_d = dbsm_pkg::REG_DR6;
			end
			dbsm_pkg::EMIT_STATUS: begin
				out_wr_d     = 1'b0;
				out_value_d  = fin_value_q;
				out_status_d = fin_status_q;
				out_slot_d   = fin_slot_q;
				out_last_d   = 1'b1;
			end
			default: begin
				out_wr_d = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		out_wr_q     <= out_wr_d;
		out_reg_q    <= out_reg_d;
		out_value_q  <= out_value_d;
		out_status_q <= out_status_d;
		out_slot_q   <= out_slot_d;
		out_last_q   <= out_last_d;
	end

	assign result_valid = out_valid_q;
	assign is_reg_write = out_wr_q;
	assign reg_number   = out_reg_q;
	assign reg_value    = out_value_q;
	assign status       = out_status_q;
	assign slot_out     = out_slot_q;
	assign last         = out_last_q;

	// The final result of an item is never a register write.
	a_last_status: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_last_q) |-> !out_wr_q)
		else $error("final result marked as a register write");

	// A register write carries no status and no slot.
	a_write_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_wr_q) |-> (out_status_q == dbsm_pkg::STAT_OK &&
		                               out_slot_q == '0 && !out_last_q))
		else $error("register write carries status fields");

	// A slot hit reported by a trap refers to an enabled slot.
	a_hit_enabled: assert property (@(posedge clk) disable iff (!arst_n)
		(dp_cmd.decide && d_status == dbsm_pkg::STAT_HIT) |->
		(slot_state_q[d_slot] == dbsm_pkg::ST_ENABLED))
		else $error("trap hit on a slot that is not enabled");

endmodule

`default_nettype wire
